@@ rtl/core/ssm_pkg.sv @@
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types and constants of the sample stream timing monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ssm_pkg;

  // fixed field widths
  localparam int CLIP_BITS      = 24;
  localparam int GAP_BITS       = 16;
  localparam int TIME_BITS      = 48;
  localparam int RATE_BITS      = 24;
  localparam int OUT_CNT_BITS   = 32;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_IDX_BITS   = 1;

  // gap test: dt*rate > gap_factor*16000, dt beyond 40 bits is a gap whenever the rate is nonzero
  localparam int GAP_DT_BITS    = 40;
  localparam int GAP_THR_BITS   = 30;
  localparam int GAP_SCALE      = 16000;
  localparam int GAP_FACTOR_RST = 24;
  localparam int PROD_BITS      = GAP_DT_BITS + RATE_BITS;
  localparam int DIFF100_BITS   = RATE_BITS + 7;

  // event counter slots
  localparam int NUM_CNT        = 6;
  localparam int IDX_SAMPLES    = 0;
  localparam int IDX_GAPS       = 1;
  localparam int IDX_OVERLAPS   = 2;
  localparam int IDX_DUPLICATES = 3;
  localparam int IDX_CLIPPED    = 4;
  localparam int IDX_RATE_CHG   = 5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CLIPPED   = 3'd1,
    ST_RATE_CHG  = 3'd2,
    ST_OVERLAP   = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_GAP       = 3'd5
  } ssm_status_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLIP_LIMIT = 1'b0,
    REG_GAP_FACTOR = 1'b1
  } ssm_reg_e;

  typedef enum logic [0:0] {
    ACT_FEED  = 1'b0,
    ACT_CLEAR = 1'b1
  } ssm_action_e;

  // counter bank control for one beat
  typedef struct packed {
    logic               clear;
    logic [NUM_CNT-1:0] bump;
  } ssm_cnt_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/ssm_in_if.sv @@
// ----------------------------------------------------------------------------
// ssm_in_if
// Input channel: one sample beat or a clear action.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssm_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [SAMPLE_BITS-1:0]       sample;
  logic        [ssm_pkg::TIME_BITS-1:0] time_ms;
  logic        [ssm_pkg::RATE_BITS-1:0] reported_rate;

  modport source (output valid, action, sample, time_ms, reported_rate, input ready);
  modport sink   (input valid, action, sample, time_ms, reported_rate, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ssm_out_if.sv @@
// ----------------------------------------------------------------------------
// ssm_out_if
// Result channel: status of one beat and the six event counts after it.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssm_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [2:0]                             status;
  logic [ssm_pkg::OUT_CNT_BITS-1:0]       sample_count;
  logic [ssm_pkg::OUT_CNT_BITS-1:0]       gap_count;
  logic [ssm_pkg::OUT_CNT_BITS-1:0]       overlap_count;
  logic [ssm_pkg::OUT_CNT_BITS-1:0]       duplicate_count;
  logic [ssm_pkg::OUT_CNT_BITS-1:0]       clip_count;
  logic [ssm_pkg::OUT_CNT_BITS-1:0]       rate_change_count;

  modport source (output valid, status, sample_count, gap_count, overlap_count,
                  duplicate_count, clip_count, rate_change_count, input ready);
  modport sink   (input valid, status, sample_count, gap_count, overlap_count,
                  duplicate_count, clip_count, rate_change_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sample_stream_timing_monitor.sv @@
// ----------------------------------------------------------------------------
// sample_stream_timing_monitor
// Per-sample status and event counts for one timestamped sample channel.
// ----------------------------------------------------------------------------
// Each beat is captured in an input register, classified against the held
// channel state (rate, last time, last sample) by compares and one 40x24
// multiply for the gap test, and its status lands in the result register
// while the counters and channel state update in the same edge. A new beat
// can be taken every cycle unless a result waits unread at the output. The
// counters themselves serve as the count fields of the result, so they move
// only when the result register is free to load. Configuration writes are
// expected only while no beat is in flight.
`default_nettype none

module sample_stream_timing_monitor #(
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [ssm_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [ssm_pkg::CFG_DATA_BITS-1:0]    cfg_wdata_i,
  // channels
  ssm_in_if.sink                               in_i,
  ssm_out_if.source                            out_o
);
  import ssm_pkg::*;

  // configuration
  logic [CLIP_BITS-1:0]     clip_limit_q;
  logic [GAP_THR_BITS-1:0]  gap_thr_q;

  // input register
  logic                     in_valid_q;
  logic                     action_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [TIME_BITS-1:0]     time_q;
  logic [RATE_BITS-1:0]     rate_q;

  // channel state
  logic                     seen_q, seen_d;
  logic [RATE_BITS-1:0]     held_rate_q, held_rate_d;
  logic [TIME_BITS-1:0]     last_time_q, last_time_d;
  logic signed [SAMPLE_BITS-1:0] last_sample_q, last_sample_d;

  // result register
  logic                     out_valid_q;
  ssm_status_e              status_q, status_d;
  ssm_cnt_ctl_t             cnt_ctl;
  logic [COUNT_BITS-1:0]    cnt [NUM_CNT];

  logic                     adv;
  logic                     in_beat;

  // handshake
  assign adv         = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || adv;
  assign in_beat     = in_i.valid && in_i.ready;

  // configuration registers, gap threshold kept pre-scaled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_limit_q <= '0;
      gap_thr_q    <= GAP_THR_BITS'(GAP_FACTOR_RST * GAP_SCALE);
    end else if (cfg_we_i) begin
      case (ssm_reg_e'(cfg_idx_i))
        REG_CLIP_LIMIT: clip_limit_q <= cfg_wdata_i[CLIP_BITS-1:0];
        REG_GAP_FACTOR: gap_thr_q    <= GAP_THR_BITS'(cfg_wdata_i[GAP_BITS-1:0]) *
                                        GAP_THR_BITS'(GAP_SCALE);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      action_q <= in_i.action;
      sample_q <= in_i.sample;
      time_q   <= in_i.time_ms;
      rate_q   <= in_i.reported_rate;
    end
  end

  // classification
  ssm_check #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_check (
    .clip_limit_i  (clip_limit_q),
    .gap_thr_i     (gap_thr_q),
    .action_i      (action_q),
    .sample_i      (sample_q),
    .time_i        (time_q),
    .rate_i        (rate_q),
    .seen_i        (seen_q),
    .held_rate_i   (held_rate_q),
    .last_time_i   (last_time_q),
    .last_sample_i (last_sample_q),
    .seen_o        (seen_d),
    .held_rate_o   (held_rate_d),
    .last_time_o   (last_time_d),
    .last_sample_o (last_sample_d),
    .status_o      (status_d),
    .cnt_ctl_o     (cnt_ctl)
  );

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= 1'b0;
      held_rate_q   <= '0;
      last_time_q   <= '0;
      last_sample_q <= '0;
    end else if (adv) begin
      seen_q        <= seen_d;
      held_rate_q   <= held_rate_d;
      last_time_q   <= last_time_d;
      last_sample_q <= last_sample_d;
    end
  end

  // event counters, also the count fields of the result
  ssm_counts #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counts (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (cnt_ctl),
    .cnt_o  (cnt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q <= status_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = status_q;
  assign out_o.sample_count      = OUT_CNT_BITS'(cnt[IDX_SAMPLES]);
  assign out_o.gap_count         = OUT_CNT_BITS'(cnt[IDX_GAPS]);
  assign out_o.overlap_count     = OUT_CNT_BITS'(cnt[IDX_OVERLAPS]);
  assign out_o.duplicate_count   = OUT_CNT_BITS'(cnt[IDX_DUPLICATES]);
  assign out_o.clip_count        = OUT_CNT_BITS'(cnt[IDX_CLIPPED]);
  assign out_o.rate_change_count = OUT_CNT_BITS'(cnt[IDX_RATE_CHG]);

`ifndef SYNTHESIS
  // a clear beat leaves every count at zero
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (action_q == ACT_CLEAR) |=>
      (cnt[IDX_SAMPLES] == '0) && (cnt[IDX_GAPS] == '0) && (cnt[IDX_OVERLAPS] == '0) &&
      (cnt[IDX_DUPLICATES] == '0) && (cnt[IDX_CLIPPED] == '0) &&
      (cnt[IDX_RATE_CHG] == '0))
    else $error("counts not cleared by clear beat");

  // a fed sample below the ceiling moves the sample count by one
  a_sample_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && (action_q == ACT_FEED) && (cnt[IDX_SAMPLES] != '1) |=>
      cnt[IDX_SAMPLES] == $past(cnt[IDX_SAMPLES]) + 1'b1)
    else $error("sample count did not advance");

  // sample count and status hold while a result waits
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(cnt[IDX_SAMPLES]) && $stable(status_q))
    else $error("result changed while stalled");

  // at most one timing event counted per beat
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> $onehot0({cnt_ctl.bump[IDX_GAPS], cnt_ctl.bump[IDX_OVERLAPS],
                      cnt_ctl.bump[IDX_DUPLICATES], cnt_ctl.bump[IDX_RATE_CHG]}))
    else $error("more than one event for a beat");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ssm_check.sv @@
// ----------------------------------------------------------------------------
// ssm_check
// Classifies one beat against the held channel state and derives the next
// state, the status and the counter bumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_check #(
  parameter int SAMPLE_BITS = 24
) (
  // configuration
  input  logic [ssm_pkg::CLIP_BITS-1:0]    clip_limit_i,
  input  logic [ssm_pkg::GAP_THR_BITS-1:0] gap_thr_i,
  // beat
  input  logic                             action_i,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic [ssm_pkg::TIME_BITS-1:0]    time_i,
  input  logic [ssm_pkg::RATE_BITS-1:0]    rate_i,
  // held state
  input  logic                             seen_i,
  input  logic [ssm_pkg::RATE_BITS-1:0]    held_rate_i,
  input  logic [ssm_pkg::TIME_BITS-1:0]    last_time_i,
  input  logic signed [SAMPLE_BITS-1:0]    last_sample_i,
  // next state
  output logic                             seen_o,
  output logic [ssm_pkg::RATE_BITS-1:0]    held_rate_o,
  output logic [ssm_pkg::TIME_BITS-1:0]    last_time_o,
  output logic signed [SAMPLE_BITS-1:0]    last_sample_o,
  // result
  output ssm_pkg::ssm_status_e             status_o,
  output ssm_pkg::ssm_cnt_ctl_t            cnt_ctl_o
);
  import ssm_pkg::*;

  localparam int MAG_BITS = (SAMPLE_BITS > CLIP_BITS) ? SAMPLE_BITS : CLIP_BITS;

  logic                    is_clear;
  logic [SAMPLE_BITS-1:0]  mag;
  logic                    clip;
  logic                    rate_nz;
  logic                    held_nz;
  logic [RATE_BITS-1:0]    diff;
  logic [DIFF100_BITS-1:0] diff100;
  logic                    rate_chg;
  logic [RATE_BITS-1:0]    eff_rate;
  logic                    back;
  logic                    dup;
  logic [TIME_BITS-1:0]    dt;
  logic                    dt_big;
  logic [PROD_BITS-1:0]    prod;
  logic                    gap;

  assign is_clear = (action_i == ACT_CLEAR);

  // magnitude and clip test
  assign mag  = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
  assign clip = (clip_limit_i != '0) &&
                (MAG_BITS'(mag) >= MAG_BITS'(clip_limit_i));

  // rate change: |new-held|*100 > held
  assign rate_nz  = (rate_i != '0);
  assign held_nz  = (held_rate_i != '0);
  assign diff     = (rate_i > held_rate_i) ? (rate_i - held_rate_i) : (held_rate_i - rate_i);
  assign diff100  = {diff, 7'b0} - {2'b0, diff, 5'b0} + {5'b0, diff, 2'b0};
  assign rate_chg = seen_i && rate_nz && held_nz &&
                    (diff100 > DIFF100_BITS'(held_rate_i));

  // rate the gap test sees: a reported rate is adopted silently over a zero one
  assign eff_rate = (rate_nz && !held_nz) ? rate_i : held_rate_i;

  // timing checks
  assign back   = (time_i < last_time_i);
  assign dup    = (time_i == last_time_i) && (sample_i == last_sample_i);
  assign dt     = time_i - last_time_i;
  assign dt_big = |dt[TIME_BITS-1:GAP_DT_BITS];
  assign prod   = PROD_BITS'(dt[GAP_DT_BITS-1:0]) * PROD_BITS'(eff_rate);
  assign gap    = (eff_rate != '0) && (dt_big || (prod > PROD_BITS'(gap_thr_i)));

  // status priority
  always_comb begin
    status_o = ST_OK;
    if (is_clear) begin
      status_o = ST_OK;
    end else if (!seen_i) begin
      status_o = clip ? ST_CLIPPED : ST_OK;
    end else if (rate_chg) begin
      status_o = ST_RATE_CHG;
    end else if (back) begin
      status_o = ST_OVERLAP;
    end else if (dup) begin
      status_o = ST_DUPLICATE;
    end else if (gap) begin
      status_o = ST_GAP;
    end else if (clip) begin
      status_o = ST_CLIPPED;
    end
  end

  // counter bumps
  always_comb begin
    cnt_ctl_o                      = '0;
    cnt_ctl_o.clear                = is_clear;
    cnt_ctl_o.bump[IDX_SAMPLES]    = !is_clear;
    cnt_ctl_o.bump[IDX_CLIPPED]    = !is_clear && clip;
    cnt_ctl_o.bump[IDX_RATE_CHG]   = !is_clear && rate_chg;
    cnt_ctl_o.bump[IDX_OVERLAPS]   = !is_clear && seen_i && !rate_chg && back;
    cnt_ctl_o.bump[IDX_DUPLICATES] = !is_clear && seen_i && !rate_chg && !back && dup;
    cnt_ctl_o.bump[IDX_GAPS]       = !is_clear && seen_i && !rate_chg && !back && !dup && gap;
  end

  // next channel state
  always_comb begin
    if (is_clear) begin
      seen_o        = 1'b0;
      held_rate_o   = '0;
      last_time_o   = '0;
      last_sample_o = '0;
    end else begin
      seen_o        = 1'b1;
      last_time_o   = time_i;
      last_sample_o = sample_i;
      if (!seen_i || (rate_nz && (!held_nz || rate_chg))) begin
        held_rate_o = rate_i;
      end else begin
        held_rate_o = held_rate_i;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ssm_counts.sv @@
// ----------------------------------------------------------------------------
// ssm_counts
// Bank of six saturating event counters with a synchronous clear.
// ----------------------------------------------------------------------------
`default_nettype none

module ssm_counts #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  ssm_pkg::ssm_cnt_ctl_t ctl_i,
  output logic [COUNT_BITS-1:0] cnt_o [ssm_pkg::NUM_CNT]
);
  import ssm_pkg::*;

  logic [COUNT_BITS-1:0] cnt_q [NUM_CNT];
  logic [COUNT_BITS-1:0] cnt_d [NUM_CNT];

  // clear, or bump below the ceiling
  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      if (ctl_i.clear) begin
        cnt_d[i] = '0;
      end else if (ctl_i.bump[i] && (cnt_q[i] != '1)) begin
        cnt_d[i] = cnt_q[i] + 1'b1;
      end else begin
        cnt_d[i] = cnt_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= '0;
    end else if (en_i) begin
      for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  assign cnt_o = cnt_q;

endmodule

`default_nettype wire
